### sv/rpfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpfc_pkg;

   typedef enum logic [2:0] {
      FMT_RGB565,
      FMT_RGB565_SW,
      FMT_BGR565,
      FMT_BGR565_SW,
      FMT_RGB888,
      FMT_GRAY8,
      FMT_MONO,
      FMT_MONO_ALT
   } fmt_type;

   typedef enum logic [1:0] {
      GM_LUMA,
      GM_AVERAGE,
      GM_EXACT_BLACK,
      GM_LUMA_ALT
   } gray_mode_type;

   localparam logic CSR_PIXEL_FORMAT = 1'b0;
   localparam logic CSR_GRAY_MODE    = 1'b1;

   localparam logic [17:0] LUMA_R = 18'd299;
   localparam logic [17:0] LUMA_G = 18'd587;
   localparam logic [17:0] LUMA_B = 18'd114;

   // Truncating division by 1000 and by 3 through a reciprocal multiply.
   localparam logic [18:0] LUMA_RECIP = 19'd268436;
   localparam int          LUMA_SHIFT = 28;
   localparam logic [10:0] AVG_RECIP  = 11'd1366;
   localparam int          AVG_SHIFT  = 12;

   typedef struct packed {
      logic [17:0] prod_r;
      logic [17:0] prod_g;
      logic [17:0] prod_b;
      logic [9:0]  sum3;
      logic        average;
   } gray_terms_type;

   typedef struct packed {
      logic        use_gray;
      logic        mono;
      logic        exact;
      logic        nonzero;
      logic [23:0] direct;
   } ctl_type;

   function automatic logic [15:0] swap16(input logic [15:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   function automatic logic [15:0] exchange_rb(input logic [15:0] v);
      return {v[4:0], v[10:5], v[15:11]};
   endfunction

   function automatic logic [15:0] pack565(input logic [7:0] r8, input logic [7:0] g8,
                                           input logic [7:0] b8);
      return {r8[7:3], g8[7:2], b8[7:3]};
   endfunction

endpackage

`default_nettype wire

### sv/rpfc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfc_front
   import rpfc_pkg::*;
(
   input  wire logic           kind,
   input  wire logic [23:0]    pixel_value,
   input  wire fmt_type        fmt,
   input  wire gray_mode_type  gmode,
   output ctl_type             ctl,
   output gray_terms_type      terms
);

   logic [15:0] v16;
   logic [7:0]  r8;
   logic [7:0]  g8;
   logic [7:0]  b8;
   logic        gray_fmt;
   logic        mono_fmt;

   assign v16 = pixel_value[15:0];
   assign r8  = {v16[15:11], v16[15:13]};
   assign g8  = {v16[10:5], v16[10:9]};
   assign b8  = {v16[4:0], v16[4:2]};

   assign mono_fmt = (fmt == FMT_MONO) || (fmt == FMT_MONO_ALT);
   assign gray_fmt = mono_fmt || (fmt == FMT_GRAY8);

   always_comb begin
      ctl.use_gray = !kind && gray_fmt;
      ctl.mono     = mono_fmt;
      ctl.exact    = (gmode == GM_EXACT_BLACK);
      ctl.nonzero  = (v16 != 16'h0000);
      ctl.direct   = '0;
      if (!kind) begin
         unique case (fmt)
            FMT_RGB565:    ctl.direct = {8'h00, v16};
            FMT_RGB565_SW: ctl.direct = {8'h00, swap16(v16)};
            FMT_BGR565:    ctl.direct = {8'h00, exchange_rb(v16)};
            FMT_BGR565_SW: ctl.direct = {8'h00, swap16(exchange_rb(v16))};
            FMT_RGB888:    ctl.direct = {r8, g8, b8};
            default:       ctl.direct = '0;
         endcase
      end else begin
         unique case (fmt)
            FMT_RGB565:    ctl.direct = {8'h00, v16};
            FMT_RGB565_SW: ctl.direct = {8'h00, swap16(v16)};
            FMT_BGR565:    ctl.direct = {8'h00, exchange_rb(v16)};
            FMT_BGR565_SW: ctl.direct = {8'h00, exchange_rb(swap16(v16))};
            FMT_RGB888:    ctl.direct = {8'h00, pack565(pixel_value[23:16],
                                                         pixel_value[15:8],
                                                         pixel_value[7:0])};
            FMT_GRAY8:     ctl.direct = {8'h00, pack565(pixel_value[7:0], pixel_value[7:0],
                                                         pixel_value[7:0])};
            default:       ctl.direct = pixel_value[0] ? 24'h00FFFF : 24'h000000;
         endcase
      end
   end

   always_comb begin
      terms.prod_r  = 18'(r8) * LUMA_R;
      terms.prod_g  = 18'(g8) * LUMA_G;
      terms.prod_b  = 18'(b8) * LUMA_B;
      terms.sum3    = 10'(r8) + 10'(g8) + 10'(b8);
      terms.average = (gmode == GM_AVERAGE);
   end

endmodule

`default_nettype wire

### sv/rpfc_gray.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfc_gray
   import rpfc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            sum_en,
   input  wire logic            div_en,
   input  wire gray_terms_type  terms,
   output logic [7:0]           gray
);

   logic [17:0] luma_ff;
   logic [17:0] luma_in;
   logic [9:0]  sum3_ff;
   logic        average_ff;
   logic [7:0]  gray_ff;
   logic [7:0]  gray_in;
   logic [36:0] luma_prod;
   logic [20:0] avg_prod;

   assign luma_in = terms.prod_r + terms.prod_g + terms.prod_b;

   assign luma_prod = 37'(luma_ff) * 37'(LUMA_RECIP);
   assign avg_prod  = 21'(sum3_ff) * 21'(AVG_RECIP);
   assign gray_in   = average_ff ? avg_prod[AVG_SHIFT +: 8] : luma_prod[LUMA_SHIFT +: 8];

   always_ff @(posedge clock) begin
      if (sum_en) begin
         luma_ff    <= luma_in;
         sum3_ff    <= terms.sum3;
         average_ff <= terms.average;
      end
      if (div_en) begin
         gray_ff <= gray_in;
      end
   end

   assign gray = gray_ff;

endmodule

`default_nettype wire

### sv/rgb565_pixel_format_codec.sv
// Throughput: one request per cycle; four register stages (format and products,
// luma sum, reciprocal multiply, output) each advance whenever the stage after is free.
// Reset: synchronous and active high; clears all stage valid bits and returns
// pixel_format and gray_mode to zero.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_pixel_format_codec
   import rpfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [23:0] req_pixel_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_result_value,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [2:0]  csr_wdata
);

   fmt_type        fmt_ff;
   gray_mode_type  gmode_ff;

   logic           valid_a_ff;
   logic           valid_b_ff;
   logic           valid_c_ff;
   logic           valid_o_ff;
   logic           en_a;
   logic           en_b;
   logic           en_c;
   logic           en_o;

   ctl_type        ctl_in;
   ctl_type        ctl_a_ff;
   ctl_type        ctl_b_ff;
   ctl_type        ctl_c_ff;
   gray_terms_type terms_in;
   gray_terms_type terms_a_ff;
   logic [7:0]     gray;
   logic [23:0]    result_ff;
   logic [23:0]    result_in;

   assign en_o = !valid_o_ff || rsp_ready;
   assign en_c = !valid_c_ff || en_o;
   assign en_b = !valid_b_ff || en_c;
   assign en_a = !valid_a_ff || en_b;
   assign req_ready = en_a;

   rpfc_front u_front (
      .kind        (req_kind),
      .pixel_value (req_pixel_value),
      .fmt         (fmt_ff),
      .gmode       (gmode_ff),
      .ctl         (ctl_in),
      .terms       (terms_in)
   );

   rpfc_gray u_gray (
      .clock  (clock),
      .sum_en (en_b),
      .div_en (en_c),
      .terms  (terms_a_ff),
      .gray   (gray)
   );

   always_comb begin
      if (!ctl_c_ff.use_gray) begin
         result_in = ctl_c_ff.direct;
      end else if (ctl_c_ff.mono) begin
         result_in = {23'd0, ctl_c_ff.exact ? ctl_c_ff.nonzero : gray[7]};
      end else begin
         result_in = {16'd0, gray};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= FMT_RGB565;
         gmode_ff   <= GM_LUMA;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_o_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PIXEL_FORMAT: fmt_ff   <= fmt_type'(csr_wdata);
               CSR_GRAY_MODE:    gmode_ff <= gray_mode_type'(csr_wdata[1:0]);
               default:          fmt_ff   <= fmt_ff;
            endcase
         end
         if (en_a) valid_a_ff <= req_valid;
         if (en_b) valid_b_ff <= valid_a_ff;
         if (en_c) valid_c_ff <= valid_b_ff;
         if (en_o) valid_o_ff <= valid_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         ctl_a_ff   <= ctl_in;
         terms_a_ff <= terms_in;
      end
      if (en_b) ctl_b_ff <= ctl_a_ff;
      if (en_c) ctl_c_ff <= ctl_b_ff;
      if (en_o) result_ff <= result_in;
   end

   assign rsp_valid        = valid_o_ff;
   assign rsp_result_value = result_ff;

endmodule

`default_nettype wire

### sv/rpfc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [23:0] rsp_result_value
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the output stage is empty");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("result missing four cycles after an unstalled request");

endmodule

bind rgb565_pixel_format_codec rpfc_checker u_rpfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value)
);

`default_nettype wire

### tb/rgb565_pixel_format_codec_tb.sv
`timescale 1ns / 1ps

module rgb565_pixel_format_codec_tb
   import rpfc_pkg::*;
();

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [23:0] req_pixel_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [23:0] rsp_result_value;
   logic        csr_wr_en;
   logic        csr_index;
   logic [2:0]  csr_wdata;

   logic [2:0]  cur_format;
   logic [1:0]  cur_gray_mode;
   logic [23:0] expected_results[$];
   logic [23:0] expected_value;
   int          error_count;
   int          burst_left;
   bit          gaps_enabled;
   int          rsp_hold_len;
   int          rsp_stall_mode;
   int          rsp_cycle;

   rgb565_pixel_format_codec u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [23:0] predict_pixel(input logic kind, input logic [23:0] v,
                                                 input logic [2:0] fmt,
                                                 input logic [1:0] gm);
      logic [15:0] p;
      logic [15:0] sw;
      logic [15:0] bgr;
      logic [4:0]  r5;
      logic [5:0]  g6;
      logic [4:0]  b5;
      logic [7:0]  r8;
      logic [7:0]  g8;
      logic [7:0]  b8;
      int unsigned rw;
      int unsigned gw;
      int unsigned bw;
      int unsigned gray;
      logic [23:0] res;
      p   = v[15:0];
      sw  = {p[7:0], p[15:8]};
      r5  = p[15:11];
      g6  = p[10:5];
      b5  = p[4:0];
      r8  = {r5, r5[4:2]};
      g8  = {g6, g6[5:4]};
      b8  = {b5, b5[4:2]};
      rw  = {24'h0, r8};
      gw  = {24'h0, g8};
      bw  = {24'h0, b8};
      if (gm == GM_AVERAGE) begin
         gray = (rw + gw + bw) / 3;
      end else begin
         gray = (rw * 299 + gw * 587 + bw * 114) / 1000;
      end
      bgr = {b5, g6, r5};
      res = 24'h0;
      if (!kind) begin
         case (fmt)
            FMT_RGB565:    res = {8'h0, p};
            FMT_RGB565_SW: res = {8'h0, sw};
            FMT_BGR565:    res = {8'h0, bgr};
            FMT_BGR565_SW: res = {8'h0, bgr[7:0], bgr[15:8]};
            FMT_RGB888:    res = {r8, g8, b8};
            FMT_GRAY8:     res = {16'h0, gray[7:0]};
            default: begin
               if (gm == GM_EXACT_BLACK) begin
                  res = {23'h0, p != 16'h0000};
               end else begin
                  res = {23'h0, gray >= 128};
               end
            end
         endcase
      end else begin
         case (fmt)
            FMT_RGB565:    res = {8'h0, p};
            FMT_RGB565_SW: res = {8'h0, sw};
            FMT_BGR565:    res = {8'h0, p[4:0], p[10:5], p[15:11]};
            FMT_BGR565_SW: res = {8'h0, sw[4:0], sw[10:5], sw[15:11]};
            FMT_RGB888:    res = {8'h0, v[23:19], v[15:10], v[7:3]};
            FMT_GRAY8:     res = {8'h0, v[7:3], v[7:2], v[7:3]};
            default:       res = v[0] ? 24'h00FFFF : 24'h000000;
         endcase
      end
      return res;
   endfunction

   // Holds req_valid until the request is taken, then records the expected pixel.
   task automatic send_pixel(input logic kind, input logic [23:0] value);
      int gap;
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_pixel_value <= value;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_pixel(kind, value, cur_format, cur_gray_mode));
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_random_pixel();
      logic [23:0] value;
      logic        kind;
      kind  = 1'($urandom_range(0, 1));
      value = 24'($urandom);
      case ($urandom_range(0, 9))
         0: value = 24'h000000;
         1: value = 24'hFFFFFF;
         2, 3: begin
            value[15:11] = 5'($urandom_range(14, 17));
            value[10:5]  = 6'($urandom_range(28, 34));
            value[4:0]   = 5'($urandom_range(14, 17));
         end
         default: ;
      endcase
      send_pixel(kind, value);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [2:0] fmt, input logic [1:0] gm);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PIXEL_FORMAT;
      csr_wdata <= fmt;
      @(posedge clock);
      csr_index <= CSR_GRAY_MODE;
      csr_wdata <= {1'b0, gm};
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      cur_format    = fmt;
      cur_gray_mode = gm;
   endtask

   task automatic test_directed();
      apply_setting(FMT_RGB888, GM_LUMA);
      send_pixel(1'b0, 24'h000000);
      send_pixel(1'b0, 24'h00FFFF);
      send_pixel(1'b0, 24'h00F800);
      send_pixel(1'b0, 24'h0007E0);
      send_pixel(1'b0, 24'hFF001F);
      send_pixel(1'b1, 24'hFFFFFF);
      send_pixel(1'b1, 24'h000000);
      apply_setting(FMT_BGR565_SW, GM_LUMA);
      send_pixel(1'b0, 24'hAB1234);
      send_pixel(1'b1, 24'hFF1234);
      apply_setting(FMT_GRAY8, GM_EXACT_BLACK);
      send_pixel(1'b0, 24'h00FFFF);
      send_pixel(1'b0, 24'h008410);
      send_pixel(1'b1, 24'hFFFF80);
      apply_setting(FMT_MONO, GM_LUMA);
      send_pixel(1'b0, 24'h008410);
      send_pixel(1'b0, 24'h007BEF);
      send_pixel(1'b1, 24'hFFFFFE);
      send_pixel(1'b1, 24'h000001);
      apply_setting(FMT_MONO, GM_AVERAGE);
      send_pixel(1'b0, 24'h008410);
      send_pixel(1'b0, 24'h007BEF);
      apply_setting(FMT_MONO, GM_EXACT_BLACK);
      send_pixel(1'b0, 24'h000000);
      send_pixel(1'b0, 24'h000001);
      send_pixel(1'b0, 24'hFF0000);
      apply_setting(FMT_MONO_ALT, GM_LUMA_ALT);
      send_pixel(1'b0, 24'h00FFFF);
      send_pixel(1'b0, 24'h000000);
   endtask

   task automatic test_random_formats();
      int phase;
      for (phase = 0; phase < 32; phase++) begin
         apply_setting(3'(phase % 8), 2'((phase / 8) % 4));
         repeat (48) send_random_pixel();
      end
   endtask

   // The result side holds off while requests keep coming, so the pipeline fills.
   task automatic test_output_stall();
      apply_setting(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      gaps_enabled = 1'b0;
      rsp_hold_len = 300;
      repeat (120) send_random_pixel();
      gaps_enabled = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      apply_setting(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      repeat (3) begin
         repeat (40) send_random_pixel();
         wait_idle();
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      rsp_stall_mode = 0;
      rsp_cycle = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end
         rsp_cycle++;
         if (rsp_cycle % 64 == 0) rsp_stall_mode = $urandom_range(0, 3);
         case (rsp_stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= (rsp_cycle % 7) < 3;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result_value: got %h with no request outstanding", rsp_result_value);
            error_count++;
         end else begin
            expected_value = expected_results.pop_front();
            if (rsp_result_value !== expected_value) begin
               $error("result_value: expected %h, actual %h", expected_value,
                      rsp_result_value);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("rgb565_pixel_format_codec: mismatch");
      $finish;
   end

   initial begin
      int drain_wait;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = 1'b0;
      req_pixel_value = 24'h0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_PIXEL_FORMAT;
      csr_wdata       = 3'h0;
      cur_format      = FMT_RGB565;
      cur_gray_mode   = GM_LUMA;
      error_count     = 0;
      burst_left      = 0;
      gaps_enabled    = 1'b1;
      rsp_hold_len    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_output_stall();
      test_random_formats();
      test_pause_until_drained();

      req_valid <= 1'b0;
      drain_wait = 0;
      while (expected_results.size() != 0 && drain_wait < 4000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("result_value: %0d expected results never arrived",
                expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("rgb565_pixel_format_codec: match");
      end else begin
         $display("rgb565_pixel_format_codec: mismatch");
      end
      $finish;
   end

endmodule

### files.f
sv/rpfc_pkg.sv
sv/rpfc_front.sv
sv/rpfc_gray.sv
sv/rgb565_pixel_format_codec.sv
sv/rpfc_checker.sv
tb/rgb565_pixel_format_codec_tb.sv
